FILE: hdl/pftd_pkg.sv
// shared constants for the trial-division factorizer
// no dependencies; used by prime_factorization_trial_division
`timescale 1ns / 1ps

package pftd_pkg;

    // results per input run; the last slot carries the unfactored remainder
    localparam int MAX_RESULTS = 31;
    localparam int K_W         = $clog2(MAX_RESULTS);

    typedef logic [K_W-1:0] result_count_t;

endpackage

FILE: hdl/prime_factorization_trial_division.sv
// prime factorization by trial division, one shared restoring divider
// depends on pftd_pkg
`timescale 1ns / 1ps

// Usage:
//   input channel : value, in_valid, in_stall. A beat is taken when in_valid
//   is high and in_stall is low. in_stall stays high from the accepted beat
//   until the run's final result has been taken.
//   output channel: factor, last, no_factors, out_valid, out_stall. The prime
//   factors come out in ascending order with repeats; the final beat of a run
//   has last = 1. Inputs 0 and 1 give one beat with factor = 0, last = 1 and
//   no_factors = 1.
//   Timing: a factor of two needs only the check state. Every odd trial divisor
//   needs the check state plus the bit-serial divider, which gives quotient
//   and remainder in one pass; the divisor square is kept by an adder, not a
//   multiplier. A 31-bit prime takes about 23170 divisors. Each result beat
//   adds an emit state that holds for any stall time. One run at a time.
//   Reset: all control state cleared, block idle and ready, no output beat.
//   A stalled output beat holds its payload and the run waits behind it.
module prime_factorization_trial_division #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic [VALUE_WIDTH-1:0] factor,
    output logic                   last,
    output logic                   no_factors,
    output logic                   out_valid,
    input  logic                   out_stall
);

    localparam int W  = VALUE_WIDTH;
    localparam int DW = (W + 1) / 2 + 1;    // trial divisor width
    localparam int SW = 2 * DW;             // divisor square width
    localparam int CW = $clog2(W);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [W-1:0]          rem_reg, rem_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [SW-1:0]         sq_reg, sq_next;
    logic [W-1:0]          q_reg, q_next;
    logic [DW-1:0]         pr_reg, pr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    pftd_pkg::result_count_t k_reg, k_next;
    logic [W-1:0]          factor_reg, factor_next;
    logic                  last_reg, last_next;
    logic                  nf_reg, nf_next;

    logic [DW:0]           trial;
    logic                  fits;
    logic [DW:0]           trial_diff;
    logic [W-1:0]          half;
    logic [SW-1:0]         rem_wide;

    // one restoring step of the shared divider
    assign trial      = {pr_reg, q_reg[W-1]};
    assign fits       = trial >= {1'b0, d_reg};
    assign trial_diff = trial - {1'b0, d_reg};
    assign half       = rem_reg >> 1;
    assign rem_wide   = {{(SW-W){1'b0}}, rem_reg};

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        q_next      = q_reg;
        pr_next     = pr_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        factor_next = factor_reg;
        last_next   = last_reg;
        nf_next     = nf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (value < W'(2))
                    begin
                        factor_next = '0;
                        last_next   = 1'b1;
                        nf_next     = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        rem_next   = value;
                        d_next     = DW'(3);
                        sq_next    = SW'(9);
                        k_next     = '0;
                        nf_next    = 1'b0;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (k_reg == pftd_pkg::result_count_t'(pftd_pkg::MAX_RESULTS - 1))
                begin
                    // result slots used up: hand out the remainder as is
                    factor_next = rem_reg;
                    last_next   = 1'b1;
                    rem_next    = W'(1);
                    state_next  = S_EMIT;
                end
                else if (!rem_reg[0])
                begin
                    factor_next = W'(2);
                    last_next   = half == W'(1);
                    rem_next    = half;
                    state_next  = S_EMIT;
                end
                else if (sq_reg <= rem_wide)
                begin
                    q_next     = rem_reg;
                    pr_next    = '0;
                    cnt_next   = CW'(W - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    // no divisor up to the square root: remainder is prime
                    factor_next = rem_reg;
                    last_next   = 1'b1;
                    rem_next    = W'(1);
                    state_next  = S_EMIT;
                end
            end
            S_DIV:
            begin
                q_next   = {q_reg[W-2:0], fits};
                pr_next  = fits ? trial_diff[DW-1:0] : trial[DW-1:0];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (pr_next == '0)
                    begin
                        factor_next = {{(W-DW){1'b0}}, d_reg};
                        last_next   = q_next == W'(1);
                        rem_next    = q_next;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        d_next     = d_reg + DW'(2);
                        sq_next    = sq_reg + {{(SW-DW-2){1'b0}}, d_reg, 2'b00} + SW'(4);
                        state_next = S_CHECK;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_stall)
                begin
                    k_next     = k_reg + pftd_pkg::result_count_t'(1);
                    state_next = last_reg ? S_IDLE : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg   <= '0;
            d_reg     <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            d_reg     <= d_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg     <= sq_next;
        q_reg      <= q_next;
        pr_reg     <= pr_next;
        factor_reg <= factor_next;
        last_reg   <= last_next;
        nf_reg     <= nf_next;
    end

    assign in_stall   = state_reg != S_IDLE;
    assign out_valid  = state_reg == S_EMIT;
    assign factor     = factor_reg;
    assign last       = last_reg;
    assign no_factors = nf_reg;

    a_div_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> d_reg[0] && d_reg >= DW'(3))
        else $error("divider running with an even or too small divisor");

    a_check_open_value: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> rem_reg > W'(1))
        else $error("factor search entered with nothing left to factor");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_factors |-> last && factor == '0)
        else $error("no-factor marker malformed");

    a_ready_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid && $past(state_reg) != S_DIV)
        else $error("input taken while a run is in progress");

endmodule

FILE: tb/sv/factor_checker.sv
// checker for the trial-division factorizer: watches both channels,
// predicts the factor beats of each accepted value and compares them
`timescale 1ns / 1ps

module factor_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] factor,
    input  logic                   last,
    input  logic                   no_factors,
    input  logic                   out_valid,
    input  logic                   out_stall,
    output int unsigned            err_count,
    output int unsigned            pending_beats
);

    typedef struct {
        logic [VALUE_WIDTH-1:0] fac;
        logic                   fin;
        logic                   no_fac;
    } factor_beat_t;

    factor_beat_t factor_q[$];
    factor_beat_t head;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic void push_beat(input longint unsigned f, input logic fin,
                                      input logic no_fac);
        factor_beat_t b;
        b.fac    = f[VALUE_WIDTH-1:0];
        b.fin    = fin;
        b.no_fac = no_fac;
        factor_q.insert(factor_q.size(), b);
    endfunction

    // ascending prime factors with repeats; the odd divisor only moves forward
    function automatic void predict_factors(input logic [VALUE_WIDTH-1:0] v);
        longint unsigned rem;
        longint unsigned div;
        longint unsigned f;
        int              k;
        rem = v;
        div = 3;
        k   = 0;
        if (rem < 2)
        begin
            push_beat(0, 1'b1, 1'b1);
            return;
        end
        while (rem > 1)
        begin
            if (k == pftd_pkg::MAX_RESULTS - 1)
            begin
                // bound reached: whole remainder goes out as the last beat
                push_beat(rem, 1'b1, 1'b0);
                break;
            end
            if (rem[0] == 1'b0)
            begin
                f = 2;
            end
            else
            begin
                while (div * div <= rem && rem % div != 0)
                    div += 2;
                f = (div * div <= rem) ? div : rem;
            end
            rem = rem / f;
            push_beat(f, rem == 1, 1'b0);
            k++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_q.delete();
            pending_beats = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (factor_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat factor=%0d last=%0b nf=%0b",
                                              factor, last, no_factors));
                end
                else
                begin
                    head = factor_q.pop_front();
                    if (factor !== head.fac)
                        report_mismatch($sformatf("factor %0d, want %0d", factor, head.fac));
                    if (last !== head.fin)
                        report_mismatch($sformatf("last %0b, want %0b (factor %0d)",
                                                  last, head.fin, head.fac));
                    if (no_factors !== head.no_fac)
                        report_mismatch($sformatf("no_factors %0b, want %0b (factor %0d)",
                                                  no_factors, head.no_fac, head.fac));
                end
            end
            // pop before push: a beat on the same edge belongs to the older run
            if (in_valid && !in_stall)
                predict_factors(value);
            pending_beats = factor_q.size();
        end
    end

endmodule

FILE: tb/sv/prime_factorization_trial_division_tb.sv
// top of the factorizer testbench: clock, reset, value stimulus and stall pattern
// depends on pftd_pkg, prime_factorization_trial_division and factor_checker
`timescale 1ns / 1ps

module prime_factorization_trial_division_tb;

    localparam int          VALUE_WIDTH  = 31;
    localparam longint      CYCLE_LIMIT  = 8_000_000;
    localparam longint unsigned MAX_VAL  = (64'd1 << VALUE_WIDTH) - 1;
    localparam int          RANDOM_ITEMS = 81;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic [VALUE_WIDTH-1:0] value;
    logic                   in_valid;
    logic                   in_stall;
    logic [VALUE_WIDTH-1:0] factor;
    logic                   last;
    logic                   no_factors;
    logic                   out_valid;
    logic                   out_stall;
    int unsigned            err_count;
    int unsigned            pending_beats;
    longint                 cycles;
    int                     burst_left;

    // extremes, squares at the divisor bound, alternating bits, a full-width prime
    logic [VALUE_WIDTH-1:0] directed_vals[$] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd9, 31'd25, 31'd121, 31'd15813251,
        31'd65521, 31'd2147024896, 31'd1073741824, 31'd1073741823,
        31'd1162261467, 31'd223092870, 31'd1431655765, 31'd715827882,
        31'd2147483646, 31'd2147483647
    };

    prime_factorization_trial_division #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .factor    (factor),
        .last      (last),
        .no_factors(no_factors),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    factor_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) factor_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .factor       (factor),
        .last         (last),
        .no_factors   (no_factors),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .err_count    (err_count),
        .pending_beats(pending_beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly cheap values: the run time grows with the root of the largest prime factor
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int              sel;
        longint unsigned p;
        longint unsigned f;
        sel = $urandom_range(0, 99);
        if (sel < 6)
        begin
            p = $urandom_range(0, 1);
        end
        else if (sel < 40)
        begin
            p = $urandom_range(2, 65535);
        end
        else if (sel < 70)
        begin
            // 18-bit mantissa slid up to reach the top bits
            p = longint'($urandom_range(1, (1 << 18) - 1)) << $urandom_range(0, 13);
        end
        else
        begin
            p = 1;
            repeat (12)
            begin
                f = $urandom_range(2, 400);
                if (p * f <= MAX_VAL)
                    p = p * f;
            end
        end
        return p[VALUE_WIDTH-1:0];
    endfunction

    task automatic feed_value(input logic [VALUE_WIDTH-1:0] v);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 6);
        end
        value    <= v;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
        burst_left--;
    endtask

    // receiver stall pattern, switching to a random mode at random intervals
    initial
    begin
        stall_mode_t mode;
        int          left;
        out_stall = 1'b0;
        mode      = STALL_NONE;
        left      = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(20, 400);
            end
            left--;
            case (mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 35);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 85);
                default:     out_stall <= ((left % 8) < 5);
            endcase
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("cycle limit hit with %0d beats outstanding", pending_beats);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        burst_left = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_vals[i])
            feed_value(directed_vals[i]);
        repeat (RANDOM_ITEMS)
            feed_value(pick_value());
        in_valid <= 1'b0;

        while (pending_beats != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
